>>> rtl/sacr_pkg.sv
`default_nettype none
package sacr_pkg;

  localparam int ENTRIES = 64;
  localparam int IDX_W = $clog2(ENTRIES);
  localparam int GEOM_MAX = 6;
  localparam logic [15:0] LFSR_SEED = 16'hACE1;

  localparam logic [1:0] POL_LRU = 2'd0;
  localparam logic [1:0] POL_LFU = 2'd1;
  localparam logic [1:0] POL_RANDOM = 2'd2;
  localparam logic [1:0] POL_MRU = 2'd3;

  localparam logic [1:0] REG_POLICY = 2'd0;
  localparam logic [1:0] REG_OFFSET = 2'd1;
  localparam logic [1:0] REG_SETS = 2'd2;
  localparam logic [1:0] REG_WAYS = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic start;
    logic step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

>>> rtl/sacr_addr_if.sv
`default_nettype none
interface sacr_addr_if;
  logic        valid;
  logic        ready;
  logic [31:0] address;
  modport source (output valid, output address, input ready);
  modport sink (input valid, input address, output ready);
endinterface
`default_nettype wire

>>> rtl/sacr_result_if.sv
`default_nettype none
interface sacr_result_if;
  logic       valid;
  logic       ready;
  logic       hit;
  logic [5:0] way_used;
  modport source (output valid, output hit, output way_used, input ready);
  modport sink (input valid, input hit, input way_used, output ready);
endinterface
`default_nettype wire

>>> rtl/set_assoc_cache_with_replacement_unit.sv
// channel  dir  payload                 handshake
// req      in   address[31:0]           valid / ready
// rsp      out  hit, way_used[5:0]      valid / ready
//
// one access at a time: accept step, then one tag/stamp memory read per way
// (registered read), stopping early on a hit, then an update step that waits
// until the output register is free.
// synchronous reset clears valid bits, time counter and control flags, reloads the lfsr seed and config defaults.
// a result waits in the output register; the next beat is taken meanwhile.
`default_nettype none
module set_assoc_cache_with_replacement_unit (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [3:0] cfg_data,
  sacr_addr_if.sink       req,
  sacr_result_if.source   rsp
);

  sacr_pkg::cmd_t    cmd;
  sacr_pkg::status_t status;

  sacr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .status   (status),
    .cmd      (cmd)
  );

  sacr_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .address   (req.address),
    .cmd       (cmd),
    .status    (status),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .out_hit   (rsp.hit),
    .out_way   (rsp.way_used)
  );

endmodule
`default_nettype wire

>>> rtl/sacr_ctrl.sv
`default_nettype none
module sacr_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire sacr_pkg::status_t status,
  output sacr_pkg::cmd_t         cmd
);

  sacr_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sacr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      sacr_pkg::ST_IDLE: begin
        if (in_valid) state_next = sacr_pkg::ST_SCAN;
      end
      sacr_pkg::ST_SCAN: begin
        if (status.scan_done) state_next = sacr_pkg::ST_UPDATE;
      end
      sacr_pkg::ST_UPDATE: begin
        if (status.out_free) state_next = sacr_pkg::ST_IDLE;
      end
      default: state_next = sacr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd = '0;
    case (state)
      sacr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.start = in_valid;
      end
      sacr_pkg::ST_SCAN: begin
        cmd.step = 1'b1;
      end
      sacr_pkg::ST_UPDATE: begin
        cmd.finish = status.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/sacr_datapath.sv
`default_nettype none
module sacr_datapath (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [3:0]        cfg_data,
  input  wire logic [31:0]       address,
  input  wire sacr_pkg::cmd_t    cmd,
  output sacr_pkg::status_t      status,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_hit,
  output logic [5:0]             out_way
);

  localparam int IW = sacr_pkg::IDX_W;
  localparam logic [3:0] LOG_E = 4'(sacr_pkg::IDX_W);
  localparam logic [3:0] GMAX = 4'(sacr_pkg::GEOM_MAX);

  // configuration
  logic [1:0] policy;
  logic [3:0] offset_bits;
  logic [2:0] set_bits;
  logic [2:0] way_bits;

  always_ff @(posedge clk) begin
    if (rst) begin
      policy <= sacr_pkg::POL_LRU;
      offset_bits <= 4'd4;
      set_bits <= 3'd0;
      way_bits <= 3'd6;
    end else if (cfg_we) begin
      case (cfg_index)
        sacr_pkg::REG_POLICY: policy <= cfg_data[1:0];
        sacr_pkg::REG_OFFSET: offset_bits <= cfg_data;
        sacr_pkg::REG_SETS:   set_bits <= cfg_data[2:0];
        sacr_pkg::REG_WAYS:   way_bits <= cfg_data[2:0];
        default: policy <= policy;
      endcase
    end
  end

  // geometry: clamp, then shrink sets before ways
  logic [3:0]    sb_c, wb_c, wb_l, sb_l;
  logic [31:0]   shifted, tag_v;
  logic [IW-1:0] set_v, base_v, ways_m1_v;

  always_comb begin
    sb_c = ({1'b0, set_bits} > GMAX) ? GMAX : {1'b0, set_bits};
    wb_c = ({1'b0, way_bits} > GMAX) ? GMAX : {1'b0, way_bits};
    wb_l = (wb_c > LOG_E) ? LOG_E : wb_c;
    sb_l = ((sb_c + wb_l) > LOG_E) ? (LOG_E - wb_l) : sb_c;
    shifted = address >> offset_bits;
    set_v = shifted[IW-1:0] & ((IW'(1) << sb_l) - IW'(1));
    tag_v = shifted >> sb_l;
    base_v = set_v << wb_l;
    ways_m1_v = (IW'(1) << wb_l) - IW'(1);
  end

  // item registers
  logic [31:0]   tag_q, now_q, access_time;
  logic [IW-1:0] base, ways_m1;
  logic [15:0]   lfsr, lfsr_next;
  logic [IW:0]   issue_cnt;
  logic          pend;
  logic [IW-1:0] pend_way;

  logic [31:0] tag_mem [sacr_pkg::ENTRIES];
  logic [31:0] stamp_mem [sacr_pkg::ENTRIES];
  logic [sacr_pkg::ENTRIES-1:0] valid;
  logic [31:0] rd_tag, rd_stamp;
  logic        rd_valid;

  logic          hit_found, inv_found;
  logic [IW-1:0] hit_way, inv_way, vic_way;
  logic [31:0]   hit_stamp, vic_stamp;

  logic          issue, match, better, take_vic, use_rand;
  logic [IW-1:0] rd_addr, way_final, wr_idx;
  logic [31:0]   wr_stamp;

  assign lfsr_next = {lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5], lfsr[15:1]};
  assign issue = cmd.step && (issue_cnt <= {1'b0, ways_m1});
  assign rd_addr = base + issue_cnt[IW-1:0];
  assign match = pend && rd_valid && (rd_tag == tag_q);

  always_comb begin
    case (policy)
      sacr_pkg::POL_LRU: better = rd_stamp < vic_stamp;
      sacr_pkg::POL_MRU: better = rd_stamp > vic_stamp;
      sacr_pkg::POL_LFU: better = rd_stamp <= vic_stamp;
      default:           better = 1'b0;
    endcase
  end
  assign take_vic = pend && ((pend_way == '0) || better);

  assign status.scan_done = pend && (match || (pend_way == ways_m1));
  assign status.out_free = !out_valid || out_ready;

  assign use_rand = !hit_found && !inv_found && (policy == sacr_pkg::POL_RANDOM);

  always_comb begin
    if (hit_found) way_final = hit_way;
    else if (inv_found) way_final = inv_way;
    else if (policy == sacr_pkg::POL_RANDOM) way_final = IW'(lfsr_next) & ways_m1;
    else way_final = vic_way;
    wr_idx = base + way_final;
    if (policy == sacr_pkg::POL_LFU) begin
      if (!hit_found) wr_stamp = '0;
      else if (hit_stamp == 32'hFFFF_FFFF) wr_stamp = hit_stamp;
      else wr_stamp = hit_stamp + 32'd1;
    end else begin
      wr_stamp = now_q;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      access_time <= '0;
      lfsr <= sacr_pkg::LFSR_SEED;
      valid <= '0;
      pend <= 1'b0;
      hit_found <= 1'b0;
      inv_found <= 1'b0;
      issue_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.start) begin
        access_time <= access_time + 32'd1;
        issue_cnt <= '0;
        pend <= 1'b0;
        hit_found <= 1'b0;
        inv_found <= 1'b0;
      end else begin
        if (issue) issue_cnt <= issue_cnt + 1'b1;
        pend <= issue;
        if (match && !hit_found) hit_found <= 1'b1;
        if (pend && !rd_valid && !inv_found) inv_found <= 1'b1;
      end
      if (cmd.finish) begin
        valid[wr_idx] <= 1'b1;
        if (use_rand) lfsr <= lfsr_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      tag_q <= tag_v;
      now_q <= access_time;
      base <= base_v;
      ways_m1 <= ways_m1_v;
    end
    if (issue) begin
      pend_way <= issue_cnt[IW-1:0];
      rd_valid <= valid[rd_addr];
    end
    if (match && !hit_found) begin
      hit_way <= pend_way;
      hit_stamp <= rd_stamp;
    end
    if (pend && !rd_valid && !inv_found) inv_way <= pend_way;
    if (take_vic) begin
      vic_way <= pend_way;
      vic_stamp <= rd_stamp;
    end
    if (cmd.finish) begin
      out_hit <= hit_found;
      out_way <= 6'(way_final);
    end
  end

  // tag and stamp memories
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      tag_mem[wr_idx] <= tag_q;
      stamp_mem[wr_idx] <= wr_stamp;
    end
    if (issue) begin
      rd_tag <= tag_mem[rd_addr];
      rd_stamp <= stamp_mem[rd_addr];
    end
  end

endmodule
`default_nettype wire
